FILE: rtl/pat_pkg.sv
package pat_pkg;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned PSIZE_W  = 16;
  localparam int unsigned JOB_W    = 25;
  localparam int unsigned PHYS_W   = 25;
  localparam int unsigned CFG_W    = 25;
  localparam int unsigned DIV_CNT_W = $clog2(ADDR_W);

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 16'd4096;
  localparam logic [JOB_W-1:0]   JOB_SIZE_RST  = 25'd16777216;

  typedef enum logic {
    CFG_PAGE_SIZE = 1'b0,
    CFG_JOB_SIZE  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_MAP       = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  map_page;
    logic [8:0]  map_frame;
    logic [23:0] logical_address;
  } pat_in_t;

  typedef struct packed {
    logic [23:0] page_number;
    logic [15:0] page_offset;
    logic [24:0] physical_address;
    logic        fault;
  } pat_out_t;

endpackage

FILE: rtl/paged_address_translation.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------
// command   | in        | start_i, busy_o         | in_i (pat_in_t)
// result    | out       | result_valid_o strobe   | result_o (pat_out_t)
// config    | in        | cfg_we_i, cfg_idx_i     | cfg_wdata_i
//
// A map transaction goes from acceptance to ST_OUT, whose result is registered;
// a translate transaction goes through ST_DIV, the restoring divider (one
// quotient bit per cycle, ADDR_W quotient bits), one page table read, one
// multiply, one output stage. busy_o is low again as the result strobe shows.
// After reset the page table is cleared one entry per cycle, all MAX_PAGES
// entries, with busy_o high. The receiver cannot stall; results are not held.
module paged_address_translation
  import pat_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 256,
  parameter int unsigned MAX_FRAMES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  pat_in_t          in_i,
  output logic             result_valid_o,
  output pat_out_t         result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_PAGES);
  localparam int unsigned FW = $clog2(MAX_FRAMES);
  localparam int unsigned PW = FW + PSIZE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PAGES - 1);

  state_e state_q, state_d;

  logic [PSIZE_W-1:0]   page_size_q;
  logic [JOB_W-1:0]     job_size_q;
  logic [IW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 done_q, done_d;

  logic                 op_q, op_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [ADDR_W-1:0]    dvd_q, dvd_d;
  logic [PSIZE_W-1:0]   rem_q, rem_d;
  logic                 valid_q, valid_d;
  logic [PW-1:0]        prod_q, prod_d;
  pat_out_t             res_q, res_d;

  logic                 accept;
  logic                 map_ok;
  logic [31:0]          page_ext;
  logic [31:0]          frame_ext;
  logic [PSIZE_W:0]     shifted;
  logic [PSIZE_W:0]     diff;
  logic                 ge;
  logic [PW:0]          sum;
  logic [63:0]          sum_ext;
  logic                 fault;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [FW:0]          ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [FW:0]          ram_rdata;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign page_ext  = 32'(in_i.map_page);
  assign frame_ext = 32'(in_i.map_frame);
  assign map_ok    = (page_ext < MAX_PAGES) && (frame_ext < MAX_FRAMES);

  // restoring divider step
  assign shifted = {rem_q, dvd_q[ADDR_W-1]};
  assign diff    = shifted - {1'b0, page_size_q};
  assign ge      = shifted >= {1'b0, page_size_q};

  assign sum     = {1'b0, prod_q} + (PW+1)'(rem_q);
  assign sum_ext = 64'(sum);

  assign fault = (page_size_q == '0) || ({1'b0, addr_q} >= job_size_q) ||
                 (32'(dvd_q) >= MAX_PAGES) || !valid_q;

  pat_ram #(
    .Width (FW + 1),
    .Depth (MAX_PAGES)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          state_d = (in_i.op == OP_MAP) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt_q == DIV_CNT_W'(ADDR_W - 1)) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    div_cnt_d = div_cnt_q;
    done_d    = 1'b0;
    op_d      = op_q;
    addr_d    = addr_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    valid_d   = valid_q;
    prod_d    = prod_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    ram_raddr = dvd_q[IW-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_d      = in_i.op;
          addr_d    = in_i.logical_address;
          dvd_d     = in_i.logical_address;
          rem_d     = '0;
          div_cnt_d = '0;
          ram_we    = (in_i.op == OP_MAP) && map_ok;
          ram_waddr = page_ext[IW-1:0];
          ram_wdata = {1'b1, frame_ext[FW-1:0]};
        end
      end
      ST_DIV: begin
        rem_d     = ge ? diff[PSIZE_W-1:0] : shifted[PSIZE_W-1:0];
        dvd_d     = {dvd_q[ADDR_W-2:0], ge};
        div_cnt_d = div_cnt_q + 1'b1;
      end
      ST_LOOK: begin
        // read address is the quotient; out-of-table pages fault anyway
      end
      ST_MUL: begin
        valid_d = ram_rdata[FW];
        prod_d  = PW'(ram_rdata[FW-1:0]) * PW'(page_size_q);
      end
      ST_OUT: begin
        done_d = 1'b1;
        res_d  = '0;
        if (op_q == OP_TRANSLATE) begin
          res_d.fault = fault;
          if (page_size_q != '0) begin
            res_d.page_number = dvd_q;
            res_d.page_offset = rem_q;
          end
          if (!fault) begin
            res_d.physical_address = sum_ext[PHYS_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      done_q      <= 1'b0;
      page_size_q <= PAGE_SIZE_RST;
      job_size_q  <= JOB_SIZE_RST;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      div_cnt_q <= div_cnt_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PAGE_SIZE: page_size_q <= cfg_wdata_i[PSIZE_W-1:0];
          CFG_JOB_SIZE:  job_size_q  <= cfg_wdata_i[JOB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    addr_q  <= addr_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    valid_q <= valid_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = done_q;
  assign result_o       = res_q;

  a_map_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.op == OP_MAP)) |-> ##2 result_valid_o)
    else $error("map transaction result missing");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a transaction in flight");

  a_page_range_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (32'(result_o.page_number) >= MAX_PAGES)) |-> result_o.fault)
    else $error("page beyond table not flagged as fault");

endmodule

FILE: rtl/pat_ram.sv
module pat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  import pat_pkg::*;

  localparam int unsigned PAGES         = 256;
  localparam int unsigned FRAMES        = 512;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned DRAIN_CYCLES  = 40;

  // Mirrors the page map and both registers; holds the results still owed by the block.
  class translation_checker;
    pat_out_t           owed_results[$];
    bit                 page_valid[PAGES];
    logic [8:0]         page_frame[PAGES];
    logic [PSIZE_W-1:0] page_size;
    logic [JOB_W-1:0]   job_size;
    int unsigned        mismatches, maps, translates, faults, reg_writes;

    function new();
      page_size = PAGE_SIZE_RST;
      job_size  = JOB_SIZE_RST;
      foreach (page_valid[i]) begin
        page_valid[i] = 1'b0;
        page_frame[i] = '0;
      end
      mismatches = 0;
      maps       = 0;
      translates = 0;
      faults     = 0;
      reg_writes = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_W-1:0] value);
      reg_writes++;
      if (idx == CFG_PAGE_SIZE) begin
        page_size = value[PSIZE_W-1:0];
      end else begin
        job_size = value[JOB_W-1:0];
      end
    endfunction

    function pat_out_t lookup_translation(pat_in_t c);
      pat_out_t   r;
      logic [31:0] quot, rem;
      logic [47:0] sum;
      r = '0;
      if (c.op == OP_MAP) begin
        maps++;
        if (c.map_page < PAGES && c.map_frame < FRAMES) begin
          page_valid[c.map_page] = 1'b1;
          page_frame[c.map_page] = c.map_frame;
        end
      end else begin
        translates++;
        if (page_size == '0) begin
          r.fault = 1'b1;
        end else begin
          quot = c.logical_address / page_size;
          rem  = c.logical_address % page_size;
          r.page_number = quot[ADDR_W-1:0];
          r.page_offset = rem[PSIZE_W-1:0];
          if (c.logical_address >= job_size || quot >= PAGES || !page_valid[quot[7:0]]) begin
            r.fault = 1'b1;
          end else begin
            sum = page_frame[quot[7:0]] * page_size + rem;
            r.physical_address = sum[PHYS_W-1:0];
          end
        end
      end
      return r;
    endfunction

    function void note_command(pat_in_t c);
      pat_out_t r;
      r = lookup_translation(c);
      owed_results = {owed_results, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(pat_out_t got);
      pat_out_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: %p", got));
      end else begin
        want = owed_results.pop_front();
        if (want.fault) faults++;
        if (got.page_number !== want.page_number)
          report($sformatf("page_number got %h want %h", got.page_number, want.page_number));
        if (got.page_offset !== want.page_offset)
          report($sformatf("page_offset got %h want %h", got.page_offset, want.page_offset));
        if (got.physical_address !== want.physical_address)
          report($sformatf("physical_address got %h want %h",
                           got.physical_address, want.physical_address));
        if (got.fault !== want.fault)
          report($sformatf("fault got %b want %b", got.fault, want.fault));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  pat_in_t          cmd;
  logic             result_valid;
  pat_out_t         result;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  translation_checker sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  paged_address_translation dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .in_i           (cmd),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Transactions are sampled with pre-edge values.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_command(cmd);
    if (rst_n && result_valid) sb.check_result(result);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_valid) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else return $urandom_range(5, 40);
  endfunction

  // Called at a rising edge; returns at the edge that accepted the command.
  task automatic issue(pat_in_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue_fields(op_e op, int unsigned page, int unsigned frame,
                              int unsigned addr);
    pat_in_t c;
    c.op              = op;
    c.map_page        = page[7:0];
    c.map_frame       = frame[8:0];
    c.logical_address = addr[ADDR_W-1:0];
    issue(c);
    pause(pick_gap());
  endtask

  // One edge first so a command accepted at the calling edge shows up as busy.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic configure(logic [PSIZE_W-1:0] ps, logic [JOB_W-1:0] js);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PAGE_SIZE;
    cfg_wdata <= CFG_W'(ps);
    @(posedge clk);
    sb.set_register(CFG_PAGE_SIZE, CFG_W'(ps));
    cfg_idx   <= CFG_JOB_SIZE;
    cfg_wdata <= CFG_W'(js);
    @(posedge clk);
    sb.set_register(CFG_JOB_SIZE, CFG_W'(js));
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    issue_fields(OP_TRANSLATE, 0, 0, 24'h000000);     // unmapped page
    issue_fields(OP_MAP, 0, 511, 0);
    issue_fields(OP_MAP, 255, 0, 0);
    issue_fields(OP_MAP, 1, 5, 0);
    issue_fields(OP_MAP, 1, 7, 24'hffffff);           // remap overwrites frame
    issue_fields(OP_TRANSLATE, 255, 511, 24'h000000);
    issue_fields(OP_TRANSLATE, 0, 0, 24'h000fff);
    issue_fields(OP_TRANSLATE, 0, 0, 24'h001abc);
    issue_fields(OP_TRANSLATE, 0, 0, 24'h0fffff);
    issue_fields(OP_TRANSLATE, 0, 0, 24'hffffff);     // page past the table
    issue_fields(OP_MAP, 255, 511, 24'hffffff);
    configure(16'd0, JOB_SIZE_RST);                   // zero page size
    issue_fields(OP_TRANSLATE, 0, 0, 24'h123456);
    configure(16'd1, 25'd0);                          // zero job size
    issue_fields(OP_TRANSLATE, 0, 0, 24'h000000);
    configure(16'd1, 25'd1);
    issue_fields(OP_TRANSLATE, 0, 0, 24'h000000);
    issue_fields(OP_TRANSLATE, 0, 0, 24'h000001);
    configure(16'hffff, JOB_SIZE_RST);
    issue_fields(OP_MAP, 2, 511, 0);
    issue_fields(OP_TRANSLATE, 0, 0, 2 * 65535 + 65534);
    issue_fields(OP_TRANSLATE, 0, 0, 24'hffffff);
  endtask

  // Mostly addresses that land inside the 256-page window, so lookups hit real entries.
  function automatic pat_in_t random_command(logic [PSIZE_W-1:0] ps);
    pat_in_t     c;
    int unsigned page, off;
    c.op              = ($urandom_range(99) < 35) ? OP_MAP : OP_TRANSLATE;
    c.map_page        = 8'($urandom_range(255));
    c.map_frame       = 9'($urandom_range(511));
    c.logical_address = ADDR_W'($urandom_range(24'hffffff));
    if (c.op == OP_TRANSLATE && ps != '0 && $urandom_range(99) < 75) begin
      page = $urandom_range(PAGES - 1);
      off  = $urandom_range(ps - 1);
      c.logical_address = ADDR_W'(page * ps + off);
    end
    return c;
  endfunction

  function automatic logic [PSIZE_W-1:0] pick_page_size(int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(99);
    if (phase == 0) return 16'd1;
    if (phase == 1) return 16'hffff;
    if (roll < 25) return 16'd1 << $urandom_range(1, 15);
    if (roll < 40) return PSIZE_W'($urandom_range(2, 16));
    return PSIZE_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [JOB_W-1:0] pick_job_size(logic [PSIZE_W-1:0] ps);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return JOB_SIZE_RST;
    if (roll < 80) return JOB_W'($urandom_range(1, PAGES * ps));
    return JOB_W'($urandom_range(1, 16777216));
  endfunction

  initial begin
    logic [PSIZE_W-1:0] ps;
    bit                 bursty;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    cmd       <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_PAGE_SIZE;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // table clear pass keeps busy high after reset
    @(posedge clk);
    drain();
    run_directed();
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      ps = pick_page_size(phase);
      configure(ps, pick_job_size(ps));
      bursty = ($urandom_range(3) == 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_command(ps));
        if (!bursty) pause(pick_gap());
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d map and %0d translate transactions, %0d of them faulting",
             sb.maps, sb.translates, sb.faults);
    $display("%0d register writes across %0d settings, %0d mismatches",
             sb.reg_writes, sb.reg_writes / 2, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
